FILE: hdl/dtws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtws_pkg: shared types and constants of the daily time window scheduler
// Field widths, opcode and result kind codes, and the command and status
// words between the controller and the datapath.
// ----------------------------------------------------------------------------
package dtws_pkg;

  // number of window entries in the table
  localparam int NUM_ENTRIES = 8;

  // field widths
  localparam int IDX_W    = 3;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int WDAY_W   = 3;

  // slots that the entry index can reach
  localparam int SLOT_MAX = 1 << IDX_W;
  localparam int SLOT_CNT = (NUM_ENTRIES < SLOT_MAX) ? NUM_ENTRIES : SLOT_MAX;
  localparam int SLOT_W   = (SLOT_CNT > 1) ? $clog2(SLOT_CNT) : 1;

  // input item opcodes
  localparam logic MODE_REGISTER = 1'b0;
  localparam logic MODE_TICK     = 1'b1;

  // result kinds
  localparam logic KIND_ANSWER = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic in_ready;    // input channel may take a word
    logic capture;     // latch the input word, restart the scan
    logic reg_commit;  // answer a registration, store it if allowed
    logic scan_step;   // advance the scan index
    logic emit;        // load a status report for the current entry
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;    // input word offered
    logic in_mode;     // opcode of the offered word
    logic out_free;    // output register can take a result this cycle
    logic cur_alloc;   // entry under the scan index is allocated
    logic scan_end;    // scan index is on the last slot
  } status_t;

endpackage

FILE: hdl/dtws_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtws_in_if: input channel of the daily time window scheduler
// Valid/ready channel carrying a registration or a time tick word.
// ----------------------------------------------------------------------------
interface dtws_in_if import dtws_pkg::*; ();

  logic                valid;
  logic                ready;
  logic                mode;
  logic [IDX_W-1:0]    entry_index;
  logic [HOUR_W-1:0]   on_hour;
  logic [MINUTE_W-1:0] on_minute;
  logic [HOUR_W-1:0]   off_hour;
  logic [MINUTE_W-1:0] off_minute;
  logic [HOUR_W-1:0]   tick_hour;
  logic [MINUTE_W-1:0] tick_minute;
  logic [SECOND_W-1:0] tick_second;
  logic [WDAY_W-1:0]   tick_weekday;

  modport source (
    output valid, mode, entry_index, on_hour, on_minute, off_hour, off_minute,
           tick_hour, tick_minute, tick_second, tick_weekday,
    input  ready
  );

  modport sink (
    input  valid, mode, entry_index, on_hour, on_minute, off_hour, off_minute,
           tick_hour, tick_minute, tick_second, tick_weekday,
    output ready
  );

endinterface

FILE: hdl/dtws_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtws_out_if: result channel of the daily time window scheduler
// Valid/ready channel carrying a registration answer or an entry status.
// ----------------------------------------------------------------------------
interface dtws_out_if import dtws_pkg::*; ();

  logic                valid;
  logic                ready;
  logic                result_kind;
  logic                accepted;
  logic [IDX_W-1:0]    report_index;
  logic                window_on;
  logic [WDAY_W-1:0]   report_weekday;
  logic [HOUR_W-1:0]   report_hour;
  logic [MINUTE_W-1:0] report_minute;
  logic [SECOND_W-1:0] report_second;
  logic                last;

  modport source (
    output valid, result_kind, accepted, report_index, window_on,
           report_weekday, report_hour, report_minute, report_second, last,
    input  ready
  );

  modport sink (
    input  valid, result_kind, accepted, report_index, window_on,
           report_weekday, report_hour, report_minute, report_second, last,
    output ready
  );

endinterface

FILE: hdl/daily_time_window_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daily_time_window_scheduler: table of daily on/off windows
//
// channel  dir  handshake     word
// in_i     in   valid/ready   registration (mode 0) or time tick (mode 1)
// out_o    out  valid/ready   registration answer or entry status report
//
// A registration is captured, then answered from the register state; a tick
// starts a scan that visits one table slot per cycle unless the output stalls.
// A new word is taken only once the previous one is fully handled; the
// output register lets the last result wait while the next word comes in.
// A stalled output holds the scan on an allocated entry until taken.
// Reset clears all allocation flags at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module daily_time_window_scheduler import dtws_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  dtws_in_if.sink    in_i,
  dtws_out_if.source out_o
);

  cmd_t    cmd;
  status_t status;

  // sequencing
  dtws_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // table, compare and output register
  dtws_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .out_o    (out_o),
    .cmd_i    (cmd),
    .status_o (status)
  );

endmodule

FILE: hdl/dtws_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtws_ctrl: controller of the daily time window scheduler
// Takes one input word at a time, answers a registration or walks the
// table one slot per cycle for a tick, stalling on a full output register.
// ----------------------------------------------------------------------------
module dtws_ctrl import dtws_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_REG  = 3'b010,
    S_SCAN = 3'b100
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.in_valid) begin
          cmd_o.capture = 1'b1;
          state_d = (status_i.in_mode == MODE_TICK) ? S_SCAN : S_REG;
        end
      end
      S_REG: begin
        if (status_i.out_free) begin
          cmd_o.reg_commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        // hold on an allocated entry until the output register frees up
        if (!status_i.cur_alloc || status_i.out_free) begin
          cmd_o.scan_step = 1'b1;
          cmd_o.emit      = status_i.cur_alloc;
          if (status_i.scan_end) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef NO_ASSERTIONS
  // never load a result over one that is still pending
  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit || cmd_o.reg_commit) |-> status_i.out_free)
    else $error("result loaded into a full output register");

  // a registration is answered in the cycle after its capture at the earliest
  a_reg_after_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.capture && status_i.in_mode == MODE_REGISTER) |=> !cmd_o.in_ready)
    else $error("input taken before registration answered");

  // a scan step without an allocated entry never emits
  a_emit_only_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (status_i.cur_alloc && cmd_o.scan_step))
    else $error("report emitted for a free slot");
`endif

endmodule

FILE: hdl/dtws_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtws_dp: datapath of the daily time window scheduler
// Input word latch, window table with allocation flags, scan index,
// window compare in minutes of day, and the output register.
// ----------------------------------------------------------------------------
module dtws_dp import dtws_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  dtws_in_if.sink        in_i,
  dtws_out_if.source     out_o,
  input  cmd_t           cmd_i,
  output status_t        status_o
);

  localparam int MDAY_W = 11;
  localparam logic [MDAY_W-1:0] MIN_PER_HOUR = MDAY_W'(60);
  localparam logic [SLOT_W-1:0] LAST_SLOT    = SLOT_W'(SLOT_CNT - 1);

  typedef struct packed {
    logic [HOUR_W-1:0]   on_hour;
    logic [MINUTE_W-1:0] on_minute;
    logic [HOUR_W-1:0]   off_hour;
    logic [MINUTE_W-1:0] off_minute;
  } window_t;

  function automatic logic [MDAY_W-1:0] day_minutes(
    input logic [HOUR_W-1:0]   h,
    input logic [MINUTE_W-1:0] m
  );
    return MDAY_W'(h) * MIN_PER_HOUR + MDAY_W'(m);
  endfunction

  // latched input word
  logic [IDX_W-1:0]    idx_q;
  window_t             win_q;
  logic [HOUR_W-1:0]   tick_hour_q;
  logic [MINUTE_W-1:0] tick_minute_q;
  logic [SECOND_W-1:0] tick_second_q;
  logic [WDAY_W-1:0]   tick_wday_q;

  // table and allocation flags
  window_t             table_q [SLOT_CNT];
  logic [SLOT_CNT-1:0] alloc_q;
  logic [SLOT_W-1:0]   scan_q;

  // output register
  logic                out_valid_q, out_valid_d;
  logic                kind_q;
  logic                accepted_q;
  logic [IDX_W-1:0]    rep_idx_q;
  logic                win_on_q;
  logic [WDAY_W-1:0]   rep_wday_q;
  logic [HOUR_W-1:0]   rep_hour_q;
  logic [MINUTE_W-1:0] rep_minute_q;
  logic [SECOND_W-1:0] rep_second_q;
  logic                last_q;

  logic                idx_ok;
  logic                reg_ok;
  logic                out_free;
  logic                later_alloc;
  logic                win_on;
  window_t             cur_win;
  logic [MDAY_W-1:0]   on_min, off_min, t_min;

  // registration check
  assign idx_ok = (IDX_W + 1)'(idx_q) < (IDX_W + 1)'(SLOT_CNT);
  assign reg_ok = idx_ok && !alloc_q[idx_q[SLOT_W-1:0]];

  // window compare for the entry under the scan index
  assign cur_win = table_q[scan_q];
  assign on_min  = day_minutes(cur_win.on_hour, cur_win.on_minute);
  assign off_min = day_minutes(cur_win.off_hour, cur_win.off_minute);
  assign t_min   = day_minutes(tick_hour_q, tick_minute_q);
  assign win_on  = (on_min < off_min) ? (on_min <= t_min && t_min < off_min)
                                      : (on_min <= t_min || t_min < off_min);

  // any allocated entry after the current one
  always_comb begin
    later_alloc = 1'b0;
    for (int j = 0; j < SLOT_CNT; j++) begin
      if (SLOT_W'(j) > scan_q) begin
        later_alloc = later_alloc | alloc_q[j];
      end
    end
  end

  assign out_free    = !out_valid_q || out_o.ready;
  assign out_valid_d = (cmd_i.reg_commit || cmd_i.emit) ? 1'b1 :
                       (out_o.ready ? 1'b0 : out_valid_q);

  // status to the controller
  assign status_o.in_valid  = in_i.valid;
  assign status_o.in_mode   = in_i.mode;
  assign status_o.out_free  = out_free;
  assign status_o.cur_alloc = alloc_q[scan_q];
  assign status_o.scan_end  = (scan_q == LAST_SLOT);

  assign in_i.ready = cmd_i.in_ready;

  // latch the input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      idx_q            <= in_i.entry_index;
      win_q.on_hour    <= in_i.on_hour;
      win_q.on_minute  <= in_i.on_minute;
      win_q.off_hour   <= in_i.off_hour;
      win_q.off_minute <= in_i.off_minute;
      tick_hour_q      <= in_i.tick_hour;
      tick_minute_q    <= in_i.tick_minute;
      tick_second_q    <= in_i.tick_second;
      tick_wday_q      <= in_i.tick_weekday;
    end
  end

  // store an accepted window
  always_ff @(posedge clk_i) begin
    if (cmd_i.reg_commit && reg_ok) begin
      table_q[idx_q[SLOT_W-1:0]] <= win_q;
    end
  end

  // allocation flags and scan index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.reg_commit && reg_ok) begin
        alloc_q[idx_q[SLOT_W-1:0]] <= 1'b1;
      end
      if (cmd_i.capture) begin
        scan_q <= '0;
      end else if (cmd_i.scan_step) begin
        scan_q <= scan_q + SLOT_W'(1);
      end
    end
  end

  // load the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.reg_commit) begin
      kind_q       <= KIND_ANSWER;
      accepted_q   <= reg_ok;
      rep_idx_q    <= idx_q;
      win_on_q     <= 1'b0;
      rep_wday_q   <= '0;
      rep_hour_q   <= '0;
      rep_minute_q <= '0;
      rep_second_q <= '0;
      last_q       <= 1'b1;
    end else if (cmd_i.emit) begin
      kind_q       <= KIND_REPORT;
      accepted_q   <= 1'b0;
      rep_idx_q    <= IDX_W'(scan_q);
      win_on_q     <= win_on;
      rep_wday_q   <= tick_wday_q;
      rep_hour_q   <= tick_hour_q;
      rep_minute_q <= tick_minute_q;
      rep_second_q <= tick_second_q;
      last_q       <= !later_alloc;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.result_kind    = kind_q;
  assign out_o.accepted       = accepted_q;
  assign out_o.report_index   = rep_idx_q;
  assign out_o.window_on      = win_on_q;
  assign out_o.report_weekday = rep_wday_q;
  assign out_o.report_hour    = rep_hour_q;
  assign out_o.report_minute  = rep_minute_q;
  assign out_o.report_second  = rep_second_q;
  assign out_o.last           = last_q;

`ifndef NO_ASSERTIONS
  // an accepted registration sets exactly one new flag
  a_alloc_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.reg_commit && reg_ok) |=>
      ($countones(alloc_q) == $past($countones(alloc_q)) + 1))
    else $error("accepted registration did not allocate one slot");

  // allocation flags never drop
  a_alloc_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.reg_commit && reg_ok) |=> (alloc_q == $past(alloc_q)))
    else $error("allocation flags changed without a registration");

  // a report from the last allocated entry of the walk is marked last
  a_last_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && !later_alloc) |=> (out_o.last && out_valid_q))
    else $error("final report not marked last");
`endif

endmodule

FILE: bench/tb_daily_time_window_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_daily_time_window_scheduler: self-checking bench for the window table
// A directed table of registrations and ticks (reset state, occupied slots,
// wrapping and always-on windows, window edges, out-of-range times) is
// followed by random traffic. Every result word is checked field by field
// against a local prediction of the table, with random gaps on both
// channels, one long output stall and one full drain pause.
// ----------------------------------------------------------------------------
module tb_daily_time_window_scheduler;
  import dtws_pkg::*;

  localparam int RANDOM_WORDS = 190;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 40;
  localparam int MIN_PER_DAY  = 1440;

  // one input word
  typedef struct {
    logic                mode;
    logic [IDX_W-1:0]    idx;
    logic [HOUR_W-1:0]   on_hour;
    logic [MINUTE_W-1:0] on_minute;
    logic [HOUR_W-1:0]   off_hour;
    logic [MINUTE_W-1:0] off_minute;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
    logic [WDAY_W-1:0]   weekday;
  } sched_word_t;

  // one result word
  typedef struct {
    logic                kind;
    logic                accepted;
    logic [IDX_W-1:0]    index;
    logic                window_on;
    logic [WDAY_W-1:0]   weekday;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
    logic                last;
  } status_word_t;

  // stored window of one slot
  typedef struct {
    logic [HOUR_W-1:0]   on_hour;
    logic [MINUTE_W-1:0] on_minute;
    logic [HOUR_W-1:0]   off_hour;
    logic [MINUTE_W-1:0] off_minute;
  } window_t;

  // how a directed row is checked
  typedef enum int {
    CHK_MODEL,   // compare against the prediction
    CHK_SILENT,  // no result at all
    CHK_ANSWER   // one registration answer, typed in the row
  } row_check_e;

  typedef struct {
    sched_word_t w;
    row_check_e  chk;
    logic        ok;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  dtws_in_if  sched_in ();
  dtws_out_if sched_out ();

  daily_time_window_scheduler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (sched_in),
    .out_o  (sched_out)
  );

  // predicted table state
  window_t             windows [SLOT_CNT];
  logic [SLOT_CNT-1:0] slot_used;

  status_word_t pending_status[$];
  int           err_count;
  logic         hold_req;
  logic         no_idle;
  stim_row_t    directed_rows[$];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("tb_daily_time_window_scheduler NOT OK");
    $finish;
  end

  task automatic flag_error(input string msg);
    err_count++;
    $display("ERROR %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got !== want) flag_error($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  function automatic logic in_window(input window_t e, input int t);
    int on_t;
    int off_t;
    on_t  = int'(e.on_hour) * 60 + int'(e.on_minute);
    off_t = int'(e.off_hour) * 60 + int'(e.off_minute);
    if (on_t < off_t) return (on_t <= t) && (t < off_t);
    return (on_t <= t) || (t < off_t);
  endfunction

  // compute the result words of one input word and update the table
  function automatic void predict_schedule(input sched_word_t w, ref status_word_t q[$]);
    status_word_t r;
    logic         ok;
    int           t;
    int           n;
    r = '{default: '0};
    n = 0;
    if (w.mode == MODE_REGISTER) begin
      ok = (int'(w.idx) < SLOT_CNT) && !slot_used[w.idx];
      if (ok) begin
        slot_used[w.idx] = 1'b1;
        windows[w.idx]   = '{w.on_hour, w.on_minute, w.off_hour, w.off_minute};
      end
      r.kind     = KIND_ANSWER;
      r.accepted = ok;
      r.index    = w.idx;
      r.last     = 1'b1;
      q.push_back(r);
    end else begin
      t = int'(w.hour) * 60 + int'(w.minute);
      for (int i = 0; i < SLOT_CNT; i++) begin
        if (slot_used[i]) begin
          r.kind      = KIND_REPORT;
          r.accepted  = 1'b0;
          r.index     = i[IDX_W-1:0];
          r.window_on = in_window(windows[i], t);
          r.weekday   = w.weekday;
          r.hour      = w.hour;
          r.minute    = w.minute;
          r.second    = w.second;
          r.last      = 1'b0;
          q.push_back(r);
          n++;
        end
      end
      if (n > 0) q[q.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic stim_row_t make_reg(input int idx, input int onh, input int onm,
                                         input int offh, input int offm,
                                         input row_check_e chk, input logic ok);
    stim_row_t row;
    row.w            = '{default: '0};
    row.w.mode       = MODE_REGISTER;
    row.w.idx        = idx[IDX_W-1:0];
    row.w.on_hour    = onh[HOUR_W-1:0];
    row.w.on_minute  = onm[MINUTE_W-1:0];
    row.w.off_hour   = offh[HOUR_W-1:0];
    row.w.off_minute = offm[MINUTE_W-1:0];
    row.chk          = chk;
    row.ok           = ok;
    return row;
  endfunction

  function automatic stim_row_t make_tick(input int h, input int m, input int s,
                                          input int wd, input row_check_e chk);
    stim_row_t row;
    row.w         = '{default: '0};
    row.w.mode    = MODE_TICK;
    row.w.hour    = h[HOUR_W-1:0];
    row.w.minute  = m[MINUTE_W-1:0];
    row.w.second  = s[SECOND_W-1:0];
    row.w.weekday = wd[WDAY_W-1:0];
    row.chk       = chk;
    row.ok        = 1'b0;
    return row;
  endfunction

  // offer one word after a gap, return at the accepting edge
  task automatic send_word(input sched_word_t w, input int gap);
    @(negedge clk_i);
    if (gap > 0) begin
      sched_in.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    sched_in.valid        <= 1'b1;
    sched_in.mode         <= w.mode;
    sched_in.entry_index  <= w.idx;
    sched_in.on_hour      <= w.on_hour;
    sched_in.on_minute    <= w.on_minute;
    sched_in.off_hour     <= w.off_hour;
    sched_in.off_minute   <= w.off_minute;
    sched_in.tick_hour    <= w.hour;
    sched_in.tick_minute  <= w.minute;
    sched_in.tick_second  <= w.second;
    sched_in.tick_weekday <= w.weekday;
    do @(posedge clk_i); while (sched_in.ready !== 1'b1);
  endtask

  // drop the input and wait until every expected word is out
  task automatic wait_drained();
    @(negedge clk_i);
    sched_in.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
  endtask

  // initial drive and reset
  initial begin
    rst_ni                 <= 1'b0;
    sched_in.valid         <= 1'b0;
    sched_in.mode          <= MODE_REGISTER;
    sched_in.entry_index   <= '0;
    sched_in.on_hour       <= '0;
    sched_in.on_minute     <= '0;
    sched_in.off_hour      <= '0;
    sched_in.off_minute    <= '0;
    sched_in.tick_hour     <= '0;
    sched_in.tick_minute   <= '0;
    sched_in.tick_second   <= '0;
    sched_in.tick_weekday  <= '0;
    sched_out.ready        <= 1'b0;
  end

  // result side: random stalls, one long hold on request
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        sched_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 4);
        if (stall > 0) begin
          sched_out.ready <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
      end
      sched_out.ready <= 1'b1;
      do @(posedge clk_i); while (sched_out.valid !== 1'b1);
    end
  end

  // check every taken result word against the oldest expectation
  always @(posedge clk_i) begin
    status_word_t got;
    status_word_t want;
    if (rst_ni && sched_out.valid === 1'b1 && sched_out.ready === 1'b1) begin
      got = '{sched_out.result_kind, sched_out.accepted, sched_out.report_index,
              sched_out.window_on, sched_out.report_weekday, sched_out.report_hour,
              sched_out.report_minute, sched_out.report_second, sched_out.last};
      if (pending_status.size() == 0) begin
        flag_error($sformatf("unexpected word kind %0d index %0d", got.kind, got.index));
      end else begin
        want = pending_status.pop_front();
        check_field("result_kind", got.kind, want.kind);
        check_field("accepted", got.accepted, want.accepted);
        check_field("report_index", got.index, want.index);
        check_field("window_on", got.window_on, want.window_on);
        check_field("report_weekday", got.weekday, want.weekday);
        check_field("report_hour", got.hour, want.hour);
        check_field("report_minute", got.minute, want.minute);
        check_field("report_second", got.second, want.second);
        check_field("last", got.last, want.last);
      end
    end
  end

  // stimulus
  initial begin
    status_word_t batch[$];
    status_word_t ans;
    sched_word_t  w;
    int           gap;
    int           sel;
    int           t;
    int           slot;
    int           base;
    int           tries;

    err_count = 0;
    hold_req  = 1'b0;
    no_idle   = 1'b0;
    slot_used = '0;
    for (int i = 0; i < SLOT_CNT; i++) windows[i] = '{default: '0};

    // directed rows
    directed_rows.push_back(make_tick(0, 0, 0, 0, CHK_SILENT));          // empty table
    directed_rows.push_back(make_tick(23, 59, 60, 6, CHK_SILENT));
    directed_rows.push_back(make_reg(0, 8, 0, 17, 30, CHK_ANSWER, 1'b1));
    directed_rows.push_back(make_reg(0, 1, 2, 3, 4, CHK_ANSWER, 1'b0));  // occupied
    directed_rows.push_back(make_tick(12, 0, 30, 3, CHK_MODEL));
    directed_rows.push_back(make_reg(7, 22, 0, 6, 0, CHK_ANSWER, 1'b1)); // wraps
    directed_rows.push_back(make_reg(3, 12, 0, 12, 0, CHK_ANSWER, 1'b1)); // always on
    directed_rows.push_back(make_reg(5, 0, 0, 23, 59, CHK_ANSWER, 1'b1));
    directed_rows.push_back(make_reg(7, 0, 0, 0, 0, CHK_ANSWER, 1'b0));  // occupied
    directed_rows.push_back(make_tick(8, 0, 0, 1, CHK_MODEL));
    directed_rows.push_back(make_tick(17, 30, 1, 2, CHK_MODEL));
    directed_rows.push_back(make_tick(17, 29, 59, 4, CHK_MODEL));
    directed_rows.push_back(make_tick(7, 59, 59, 5, CHK_MODEL));
    directed_rows.push_back(make_tick(22, 0, 0, 6, CHK_MODEL));
    directed_rows.push_back(make_tick(5, 59, 10, 0, CHK_MODEL));
    directed_rows.push_back(make_tick(6, 0, 20, 1, CHK_MODEL));
    directed_rows.push_back(make_tick(0, 0, 0, 0, CHK_MODEL));
    directed_rows.push_back(make_tick(23, 59, 60, 6, CHK_MODEL));
    directed_rows.push_back(make_reg(6, 31, 63, 0, 0, CHK_ANSWER, 1'b1)); // beyond range
    directed_rows.push_back(make_tick(31, 63, 63, 7, CHK_MODEL));
    directed_rows.push_back(make_tick(16, 42, 42, 2, CHK_MODEL));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // walk the directed table
    foreach (directed_rows[k]) begin
      send_word(directed_rows[k].w, $urandom_range(0, 4));
      batch.delete();
      predict_schedule(directed_rows[k].w, batch);
      if (directed_rows[k].chk == CHK_MODEL) begin
        foreach (batch[j]) pending_status.push_back(batch[j]);
      end else if (directed_rows[k].chk == CHK_ANSWER) begin
        ans          = '{default: '0};
        ans.kind     = KIND_ANSWER;
        ans.accepted = directed_rows[k].ok;
        ans.index    = directed_rows[k].w.idx;
        ans.last     = 1'b1;
        pending_status.push_back(ans);
      end
    end
    wait_drained();

    // random traffic
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      w       = '{default: '0};
      no_idle = (n >= 140) && (n < 170);
      sel     = $urandom_range(0, 99);
      if (n >= 60 && n < 66) sel = 99;  // ticks while the output is held
      if (sel < 25) begin
        w.mode = MODE_REGISTER;
        w.idx  = IDX_W'($urandom_range(0, SLOT_CNT - 1));
        if ($urandom_range(0, 99) < 15) begin
          w.on_hour    = HOUR_W'($urandom);
          w.on_minute  = MINUTE_W'($urandom);
          w.off_hour   = HOUR_W'($urandom);
          w.off_minute = MINUTE_W'($urandom);
        end else begin
          w.on_hour    = HOUR_W'($urandom_range(0, 23));
          w.on_minute  = MINUTE_W'($urandom_range(0, 59));
          w.off_hour   = HOUR_W'($urandom_range(0, 23));
          w.off_minute = MINUTE_W'($urandom_range(0, 59));
        end
        if ($urandom_range(0, 99) < 15) begin
          w.off_hour   = w.on_hour;
          w.off_minute = w.on_minute;
        end
      end else begin
        w.mode = MODE_TICK;
        sel    = $urandom_range(0, 99);
        if (sel < 15) begin
          w.hour    = HOUR_W'($urandom);
          w.minute  = MINUTE_W'($urandom);
          w.second  = SECOND_W'($urandom);
          w.weekday = WDAY_W'($urandom);
        end else begin
          w.hour    = HOUR_W'($urandom_range(0, 23));
          w.minute  = MINUTE_W'($urandom_range(0, 59));
          w.second  = SECOND_W'($urandom_range(0, 60));
          w.weekday = WDAY_W'($urandom_range(0, 6));
          if (sel < 50 && slot_used != '0) begin
            // land on or next to an edge of an allocated window
            slot  = $urandom_range(0, SLOT_CNT - 1);
            tries = 0;
            while (!slot_used[slot] && tries < 64) begin
              slot = $urandom_range(0, SLOT_CNT - 1);
              tries++;
            end
            if (slot_used[slot]) begin
              if ($urandom_range(0, 1))
                base = int'(windows[slot].on_hour) * 60 + int'(windows[slot].on_minute);
              else
                base = int'(windows[slot].off_hour) * 60 + int'(windows[slot].off_minute);
              t        = (base + $urandom_range(0, 2) - 1 + MIN_PER_DAY) % MIN_PER_DAY;
              w.hour   = HOUR_W'(t / 60);
              w.minute = MINUTE_W'(t % 60);
            end
          end
        end
      end

      if (n == 60) hold_req = 1'b1;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      send_word(w, gap);
      batch.delete();
      predict_schedule(w, batch);
      foreach (batch[j]) pending_status.push_back(batch[j]);

      // pause the input until every result is out
      if (n == 120) wait_drained();
    end

    @(negedge clk_i);
    sched_in.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_count == 0 && pending_status.size() == 0) begin
      $display("tb_daily_time_window_scheduler OK");
    end else begin
      $display("tb_daily_time_window_scheduler NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/dtws_pkg.sv
hdl/dtws_in_if.sv
hdl/dtws_out_if.sv
hdl/dtws_ctrl.sv
hdl/dtws_dp.sv
hdl/daily_time_window_scheduler.sv
bench/tb_daily_time_window_scheduler.sv
